>>> hdl/mmsf_pkg.sv
// Package for the maximal/minimal set filter.
// Holds default sizes, fixed field widths and the sequencer state type.
// No dependencies.
package mmsf_pkg;

   localparam int MAX_SETS_DEFAULT     = 32;
   localparam int MAX_ELEMENTS_DEFAULT = 256;
   localparam int KEY_WIDTH_DEFAULT    = 16;

   // fixed widths of the item fields
   localparam int ELEMENT_KEY_W = 16;
   localparam int SET_INDEX_W   = 5;

   typedef enum logic [10:0] {
      ST_LOAD  = 11'b000_0000_0001,
      ST_A_RD  = 11'b000_0000_0010,
      ST_A_GET = 11'b000_0000_0100,
      ST_B_RD  = 11'b000_0000_1000,
      ST_B_GET = 11'b000_0001_0000,
      ST_TEST  = 11'b000_0010_0000,
      ST_X_RD  = 11'b000_0100_0000,
      ST_X_GET = 11'b000_1000_0000,
      ST_Y_RD  = 11'b001_0000_0000,
      ST_Y_GET = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

endpackage

>>> hdl/mmsf_req_if.sv
// Input channel of the set filter: one element item per handshake.
// Depends on mmsf_pkg for the key width.
interface mmsf_req_if;
   logic                               valid;
   logic                               ready;
   logic [mmsf_pkg::ELEMENT_KEY_W-1:0] element_key;
   logic                               no_element;
   logic                               set_last;
   logic                               list_last;

   modport source (output valid, element_key, no_element, set_last, list_last,
                   input ready);
   modport sink   (input valid, element_key, no_element, set_last, list_last,
                   output ready);
endinterface

>>> hdl/mmsf_rsp_if.sv
// Result channel of the set filter: one keep flag item per set.
// Depends on mmsf_pkg for the set index width.
interface mmsf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mmsf_pkg::SET_INDEX_W-1:0] set_index;
   logic                             keep;
   logic                             overflow;
   logic                             last;

   modport source (output valid, set_index, keep, overflow, last, input ready);
   modport sink   (input valid, set_index, keep, overflow, last, output ready);
endinterface

>>> hdl/maximal_minimal_set_filter_top.sv
// Maximal/minimal set filter, top level. Depends on mmsf_pkg, mmsf_req_if,
// mmsf_rsp_if and mmsf_ram.
// Load: one element item per cycle. Filter: a read and a get state per set bound
// fetch, a test state per pair, then element reads on the single element read port.
// Output: one result item per cycle while not stalled, then ready for the next list.
// Reset (synchronous, active high) empties the list, sets all keep flags, keep_mode=0.
module maximal_minimal_set_filter_top #(
   parameter int MAX_SETS     = mmsf_pkg::MAX_SETS_DEFAULT,
   parameter int MAX_ELEMENTS = mmsf_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int KEY_WIDTH    = mmsf_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mmsf_req_if.sink   req_ch,
   mmsf_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   // set index / set count widths
   localparam int SIDX_W = $clog2(MAX_SETS);
   localparam int SCNT_W = $clog2(MAX_SETS + 1);
   // element address / element count widths
   localparam int EIDX_W = $clog2(MAX_ELEMENTS);
   localparam int ECNT_W = $clog2(MAX_ELEMENTS + 1);
   // keys compare in their low KEY_WIDTH bits, never more than the field
   localparam int STORE_W = (KEY_WIDTH < mmsf_pkg::ELEMENT_KEY_W) ?
                            KEY_WIDTH : mmsf_pkg::ELEMENT_KEY_W;

   mmsf_pkg::state_type state_ff, state_in;

   logic [ECNT_W-1:0]   elem_cnt_ff, elem_cnt_in;
   logic [SCNT_W-1:0]   set_cnt_ff, set_cnt_in;
   logic                ovf_ff, ovf_in;
   logic                mode_ff;
   logic [MAX_SETS-1:0] keep_ff, keep_in;

   // walk counters: a = earlier set, b = later set, k = result index
   logic [SCNT_W-1:0] a_ff, a_in, b_ff, b_in, k_ff, k_in;
   // element positions inside the subset test
   logic [ECNT_W-1:0] i_ff, i_in, j_ff, j_in;
   // bounds [as,ae) of set a and [bs,be) of set b
   logic [ECNT_W-1:0] as_ff, as_in, ae_ff, ae_in, bs_ff, bs_in, be_ff, be_in;
   logic [STORE_W-1:0] xkey_ff, xkey_in;

   // load side
   logic              req_fire, rsp_fire;
   logic              elem_wr, end_wr, close;
   logic [ECNT_W-1:0] elem_cnt_nx;
   logic [SCNT_W-1:0] set_cnt_nx;

   // memories
   logic [STORE_W-1:0] elem_rd_data;
   logic [ECNT_W-1:0]  end_rd_data;
   logic [ECNT_W-1:0]  elem_rd_pos;
   logic [SCNT_W-1:0]  end_rd_pos;

   // walk helpers
   logic [ECNT_W-1:0] xs, xe, ys, ye;
   logic [SCNT_W-1:0] a_nx, b_nx, kidx;
   logic              a_more, b_more, next_b, advance_a, keep_rd, out_last;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // ------------------------------------------------------------------
   // Loading: drop elements once either store is full, drop closes once
   // the set store is full; any drop marks the list as overflowed.
   // ------------------------------------------------------------------
   assign elem_wr = req_fire && !req_ch.no_element &&
                    (set_cnt_ff < SCNT_W'(MAX_SETS)) &&
                    (elem_cnt_ff < ECNT_W'(MAX_ELEMENTS));
   assign close   = req_fire && (req_ch.set_last || req_ch.list_last);
   assign end_wr  = close && (set_cnt_ff < SCNT_W'(MAX_SETS));
   assign elem_cnt_nx = elem_cnt_ff + ECNT_W'(elem_wr);
   assign set_cnt_nx  = set_cnt_ff + SCNT_W'(end_wr);

   // Subset orientation: maximal mode tests B within A, minimal mode A within B.
   assign xs = mode_ff ? as_ff : bs_ff;
   assign xe = mode_ff ? ae_ff : be_ff;
   assign ys = mode_ff ? bs_ff : as_ff;
   assign ye = mode_ff ? be_ff : ae_ff;

   assign a_nx   = a_ff + SCNT_W'(1);
   assign b_nx   = b_ff + SCNT_W'(1);
   assign a_more = (a_nx + SCNT_W'(1)) < set_cnt_ff;
   assign b_more = b_nx < set_cnt_ff;

   // single read of the keep flags, address picked by the walk phase
   always_comb begin
      if (state_ff == mmsf_pkg::ST_OUT) begin
         kidx = k_ff;
      end else if (state_ff == mmsf_pkg::ST_A_GET) begin
         kidx = a_ff;
      end else begin
         kidx = b_ff;
      end
   end
   assign keep_rd = keep_ff[kidx[SIDX_W-1:0]];

   assign elem_rd_pos = (state_ff == mmsf_pkg::ST_X_RD) ? i_ff : j_ff;
   assign end_rd_pos  = (state_ff == mmsf_pkg::ST_A_RD) ? a_ff : b_ff;
   assign out_last    = (k_ff + SCNT_W'(1)) == set_cnt_ff;

   mmsf_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr),
      .wr_addr (elem_cnt_ff[EIDX_W-1:0]),
      .wr_data (req_ch.element_key[STORE_W-1:0]),
      .rd_addr (elem_rd_pos[EIDX_W-1:0]),
      .rd_data (elem_rd_data)
   );

   // exclusive end position of each closed set
   mmsf_ram #(
      .WIDTH (ECNT_W),
      .DEPTH (MAX_SETS)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (end_wr),
      .wr_addr (set_cnt_ff[SIDX_W-1:0]),
      .wr_data (elem_cnt_nx),
      .rd_addr (end_rd_pos[SIDX_W-1:0]),
      .rd_data (end_rd_data)
   );

   // ------------------------------------------------------------------
   // Sequencer. Walk order follows the greedy pass: for each kept set a,
   // each later kept set b is tested and possibly dropped. The single
   // element read port is shared: X_RD/X_GET fetch one element of the
   // tested set, Y_RD/Y_GET scan the other set for a match.
   // ------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      elem_cnt_in = elem_cnt_ff;
      set_cnt_in  = set_cnt_ff;
      ovf_in      = ovf_ff;
      keep_in     = keep_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      as_in       = as_ff;
      ae_in       = ae_ff;
      bs_in       = bs_ff;
      be_in       = be_ff;
      xkey_in     = xkey_ff;
      next_b      = 1'b0;
      advance_a   = 1'b0;

      unique case (state_ff)
         mmsf_pkg::ST_LOAD: begin
            if (req_fire) begin
               elem_cnt_in = elem_cnt_nx;
               set_cnt_in  = set_cnt_nx;
               if ((!req_ch.no_element && !elem_wr) || (close && !end_wr)) begin
                  ovf_in = 1'b1;
               end
               if (req_ch.list_last) begin
                  a_in  = '0;
                  as_in = '0;
                  k_in  = '0;
                  state_in = (set_cnt_nx > SCNT_W'(1)) ? mmsf_pkg::ST_A_RD
                                                       : mmsf_pkg::ST_OUT;
               end
            end
         end
         mmsf_pkg::ST_A_RD: begin
            state_in = mmsf_pkg::ST_A_GET;
         end
         mmsf_pkg::ST_A_GET: begin
            ae_in = end_rd_data;
            if (keep_rd) begin
               b_in     = a_nx;
               bs_in    = end_rd_data;
               state_in = mmsf_pkg::ST_B_RD;
            end else begin
               advance_a = 1'b1;
            end
         end
         mmsf_pkg::ST_B_RD: begin
            state_in = mmsf_pkg::ST_B_GET;
         end
         mmsf_pkg::ST_B_GET: begin
            be_in    = end_rd_data;
            state_in = mmsf_pkg::ST_TEST;
         end
         mmsf_pkg::ST_TEST: begin
            // dropped set, or empty tested set: nothing to do
            if (!keep_rd || (xs >= xe)) begin
               next_b = 1'b1;
            end else begin
               i_in     = xs;
               state_in = mmsf_pkg::ST_X_RD;
            end
         end
         mmsf_pkg::ST_X_RD: begin
            state_in = mmsf_pkg::ST_X_GET;
         end
         mmsf_pkg::ST_X_GET: begin
            xkey_in = elem_rd_data;
            j_in    = ys;
            if (ys >= ye) begin
               next_b = 1'b1;
            end else begin
               state_in = mmsf_pkg::ST_Y_RD;
            end
         end
         mmsf_pkg::ST_Y_RD: begin
            state_in = mmsf_pkg::ST_Y_GET;
         end
         mmsf_pkg::ST_Y_GET: begin
            if (elem_rd_data == xkey_ff) begin
               i_in = i_ff + ECNT_W'(1);
               if ((i_ff + ECNT_W'(1)) >= xe) begin
                  // every element found: subset, drop set b
                  keep_in[b_ff[SIDX_W-1:0]] = 1'b0;
                  next_b = 1'b1;
               end else begin
                  state_in = mmsf_pkg::ST_X_RD;
               end
            end else begin
               j_in = j_ff + ECNT_W'(1);
               if ((j_ff + ECNT_W'(1)) >= ye) begin
                  next_b = 1'b1;
               end else begin
                  state_in = mmsf_pkg::ST_Y_RD;
               end
            end
         end
         mmsf_pkg::ST_OUT: begin
            if (rsp_fire) begin
               if (out_last) begin
                  keep_in     = '1;
                  elem_cnt_in = '0;
                  set_cnt_in  = '0;
                  ovf_in      = 1'b0;
                  state_in    = mmsf_pkg::ST_LOAD;
               end else begin
                  k_in = k_ff + SCNT_W'(1);
               end
            end
         end
         default: begin
            state_in = mmsf_pkg::ST_LOAD;
         end
      endcase

      // next later set: its start is the end of the one just tested
      if (next_b) begin
         if (b_more) begin
            bs_in    = be_ff;
            b_in     = b_nx;
            state_in = mmsf_pkg::ST_B_RD;
         end else begin
            advance_a = 1'b1;
         end
      end

      // next earlier set: its start is the end of set a
      if (advance_a) begin
         as_in = (state_ff == mmsf_pkg::ST_A_GET) ? end_rd_data : ae_ff;
         a_in  = a_nx;
         if (a_more) begin
            state_in = mmsf_pkg::ST_A_RD;
         end else begin
            k_in     = '0;
            state_in = mmsf_pkg::ST_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mmsf_pkg::ST_LOAD;
         elem_cnt_ff <= '0;
         set_cnt_ff  <= '0;
         ovf_ff      <= 1'b0;
         keep_ff     <= '1;
         mode_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         elem_cnt_ff <= elem_cnt_in;
         set_cnt_ff  <= set_cnt_in;
         ovf_ff      <= ovf_in;
         keep_ff     <= keep_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // walk payload registers need no reset
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      as_ff   <= as_in;
      ae_ff   <= ae_in;
      bs_ff   <= bs_in;
      be_ff   <= be_in;
      xkey_ff <= xkey_in;
   end

   // ------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------
   assign req_ch.ready     = (state_ff == mmsf_pkg::ST_LOAD);
   assign rsp_ch.valid     = (state_ff == mmsf_pkg::ST_OUT);
   assign rsp_ch.set_index = mmsf_pkg::SET_INDEX_W'(k_ff);
   assign rsp_ch.keep      = keep_rd;
   assign rsp_ch.overflow  = ovf_ff;
   assign rsp_ch.last      = out_last;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while results pending");

   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmsf_pkg::ST_OUT) |-> (k_ff < set_cnt_ff))
      else $error("result index beyond set count");

   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.list_last) |=> !req_ch.ready)
      else $error("input not stalled after list close");

   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last) |=> (req_ch.ready && (set_cnt_ff == '0) && !ovf_ff))
      else $error("list not cleared after final result");

endmodule

>>> hdl/mmsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on mmsf_pkg for default sizes.
module mmsf_ram #(
   parameter int WIDTH = mmsf_pkg::KEY_WIDTH_DEFAULT,
   parameter int DEPTH = mmsf_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/mmsf_keep_checker.sv
`timescale 1ns / 1ps
// Checker for the maximal/minimal set filter: follows both channels and the
// keep_mode write port, predicts one keep result per set and compares them.
// Depends on mmsf_pkg, mmsf_req_if and mmsf_rsp_if.
module mmsf_keep_checker #(
   parameter int MAX_SETS     = mmsf_pkg::MAX_SETS_DEFAULT,
   parameter int MAX_ELEMENTS = mmsf_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int KEY_WIDTH    = mmsf_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mmsf_req_if  req_ch,
   mmsf_rsp_if  rsp_ch,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   mismatch_count,
   output int   keeps_pending
);

   typedef struct packed {
      logic [mmsf_pkg::SET_INDEX_W-1:0] set_index;
      logic                             keep;
      logic                             overflow;
      logic                             last;
   } keep_result_type;

   // keys compare in their low KEY_WIDTH bits only
   localparam logic [mmsf_pkg::ELEMENT_KEY_W-1:0] KEY_MASK =
      mmsf_pkg::ELEMENT_KEY_W'((64'd1 << KEY_WIDTH) - 64'd1);

   logic [mmsf_pkg::ELEMENT_KEY_W-1:0] stored_keys [MAX_ELEMENTS];
   int                                 set_ends [MAX_SETS];
   bit                                 keep_flags [MAX_SETS];
   int                                 key_count;
   int                                 set_count;
   bit                                 overflow_seen;
   bit                                 minimal_mode;
   int                                 errors;
   keep_result_type                    predicted_keeps [$];

   // every key of [x_lo,x_hi) also occurs in [y_lo,y_hi); empty x never counts
   function automatic bit contained_in(int x_lo, int x_hi, int y_lo, int y_hi);
      bit found;
      if (x_lo >= x_hi)
         return 1'b0;
      for (int i = x_lo; i < x_hi; i++) begin
         found = 1'b0;
         for (int j = y_lo; j < y_hi; j++)
            if (stored_keys[i] == stored_keys[j])
               found = 1'b1;
         if (!found)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : predict_and_compare
      keep_result_type want;
      int n, a_lo, a_hi, b_lo, b_hi;
      if (reset) begin
         errors        = 0;
         key_count     = 0;
         set_count     = 0;
         overflow_seen = 1'b0;
         minimal_mode  = 1'b0;
         predicted_keeps.delete();
      end else begin
         if (csr_wr_en)
            minimal_mode = csr_wr_data;

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_keeps.size() == 0) begin
               errors++;
               $display("%0t: result with none expected: set_index %0d keep %0b",
                        $time, rsp_ch.set_index, rsp_ch.keep);
            end else begin
               want = predicted_keeps.pop_front();
               if (rsp_ch.set_index !== want.set_index) begin
                  errors++;
                  $display("%0t: set_index expected %0d actual %0d",
                           $time, want.set_index, rsp_ch.set_index);
               end
               if (rsp_ch.keep !== want.keep) begin
                  errors++;
                  $display("%0t: keep of set %0d expected %0b actual %0b",
                           $time, want.set_index, want.keep, rsp_ch.keep);
               end
               if (rsp_ch.overflow !== want.overflow) begin
                  errors++;
                  $display("%0t: overflow of set %0d expected %0b actual %0b",
                           $time, want.set_index, want.overflow, rsp_ch.overflow);
               end
               if (rsp_ch.last !== want.last) begin
                  errors++;
                  $display("%0t: last of set %0d expected %0b actual %0b",
                           $time, want.set_index, want.last, rsp_ch.last);
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            if (!req_ch.no_element) begin
               if (set_count >= MAX_SETS || key_count >= MAX_ELEMENTS) begin
                  overflow_seen = 1'b1;
               end else begin
                  stored_keys[key_count] = req_ch.element_key & KEY_MASK;
                  key_count++;
               end
            end
            if (req_ch.set_last || req_ch.list_last) begin
               if (set_count >= MAX_SETS) begin
                  overflow_seen = 1'b1;
               end else begin
                  set_ends[set_count] = key_count;
                  set_count++;
               end
            end
            if (req_ch.list_last) begin
               n = set_count;
               for (int a = 0; a < MAX_SETS; a++)
                  keep_flags[a] = 1'b1;
               // greedy forward walk: only later sets can be dropped
               for (int a = 0; a + 1 < n; a++) begin
                  if (!keep_flags[a])
                     continue;
                  a_lo = (a == 0) ? 0 : set_ends[a - 1];
                  a_hi = set_ends[a];
                  for (int b = a + 1; b < n; b++) begin
                     if (!keep_flags[b])
                        continue;
                     b_lo = set_ends[b - 1];
                     b_hi = set_ends[b];
                     if (minimal_mode ? contained_in(a_lo, a_hi, b_lo, b_hi)
                                      : contained_in(b_lo, b_hi, a_lo, a_hi))
                        keep_flags[b] = 1'b0;
                  end
               end
               for (int a = 0; a < n; a++) begin
                  want.set_index = mmsf_pkg::SET_INDEX_W'(a);
                  want.keep      = keep_flags[a];
                  want.overflow  = overflow_seen;
                  want.last      = (a == n - 1);
                  predicted_keeps.push_back(want);
               end
               key_count     = 0;
               set_count     = 0;
               overflow_seen = 1'b0;
            end
         end
      end
      mismatch_count <= errors;
      keeps_pending  <= predicted_keeps.size();
   end

endmodule

>>> test/maximal_minimal_set_filter_top_tb.sv
`timescale 1ns / 1ps
// Top of the set filter testbench: clock, reset, keep_mode writes, element
// stimulus and result back-pressure; the checker beside the block does the
// predicting. Depends on mmsf_pkg, both channel interfaces and mmsf_keep_checker.
module maximal_minimal_set_filter_top_tb;

   localparam bit KEEP_MAXIMAL  = 1'b0;
   localparam bit KEEP_MINIMAL  = 1'b1;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 120;
   localparam int HOLD_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   int   cycle_count = 0;
   int   mismatch_count;
   int   keeps_pending;
   bit   sender_steady;   // no gaps on the element side while set

   mmsf_req_if req_ch ();
   mmsf_rsp_if rsp_ch ();

   maximal_minimal_set_filter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mmsf_keep_checker u_keep_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .keeps_pending  (keeps_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: far above the slowest legal run, which is dominated by the
   // pairwise walk of the full 32-set list
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one element item. Gaps come before the item, so valid only drops
   // in a step that is followed by at least one idle edge.
   task automatic send_item(input logic [mmsf_pkg::ELEMENT_KEY_W-1:0] key,
                            input bit no_elem, input bit close_set,
                            input bit close_list);
      while (!sender_steady && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.element_key <= key;
      req_ch.no_element  <= no_elem;
      req_ch.set_last    <= close_set;
      req_ch.list_last   <= close_list;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Stop offering and wait until every predicted result has come back; the
   // extra edge first lets the checker see the last list close.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (keeps_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // keep_mode only changes with the block idle between lists
   task automatic write_mode(input bit mode);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One well-formed list with random content. Narrow lists draw keys from a
   // pool of four so that containment actually happens. Some sets close with
   // a separate no-element item, the final close may omit set_last, and now
   // and then an ignored item is slipped in.
   task automatic send_list(input int n_sets, input int max_keys, input bit narrow,
                            inout int sent);
      logic [mmsf_pkg::ELEMENT_KEY_W-1:0] base;
      logic [mmsf_pkg::ELEMENT_KEY_W-1:0] key;
      int s, e, n_keys;
      bit final_set, late_close, set_flag, marks_end;
      base = mmsf_pkg::ELEMENT_KEY_W'($urandom);
      for (s = 0; s < n_sets; s++) begin
         final_set  = (s == n_sets - 1);
         n_keys     = $urandom_range(max_keys);
         late_close = (n_keys > 0) && ($urandom_range(3) == 0);
         set_flag   = !final_set || ($urandom_range(1) == 1);
         if ($urandom_range(9) == 0)
            send_item(mmsf_pkg::ELEMENT_KEY_W'($urandom), 1'b1, 1'b0, 1'b0);
         for (e = 0; e < n_keys; e++) begin
            key = narrow ? (base ^ mmsf_pkg::ELEMENT_KEY_W'($urandom_range(3)))
                         : mmsf_pkg::ELEMENT_KEY_W'($urandom);
            marks_end = (e == n_keys - 1) && !late_close;
            send_item(key, 1'b0, marks_end && set_flag, marks_end && final_set);
            sent++;
         end
         if (n_keys == 0 || late_close) begin
            send_item(mmsf_pkg::ELEMENT_KEY_W'($urandom), 1'b1, set_flag, final_set);
            sent++;
         end
      end
   endtask

   // result side: random stalls, one long hold-off once results are flowing,
   // and a stretch of results taken back to back
   initial begin : result_side
      int results_taken = 0;
      int hold_left     = 0;
      bit hold_done     = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            results_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && results_taken >= 20) begin
            // lands inside the full-store list while the next list is offered
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (results_taken >= 40 && results_taken < 90) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 32);
         end
      end
   end

   initial begin : element_side
      logic [mmsf_pkg::ELEMENT_KEY_W-1:0] base;
      int i;
      int spare_count  = 0;
      int random_items = 0;
      int list_no      = 0;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.element_key <= '0;
      req_ch.no_element  <= 1'b0;
      req_ch.set_last    <= 1'b0;
      req_ch.list_last   <= 1'b0;
      sender_steady      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // maximal mode, hand-made list
      write_mode(KEEP_MAXIMAL);
      send_item(16'h0000, 1'b0, 1'b0, 1'b0);
      send_item(16'hFFFF, 1'b0, 1'b0, 1'b0);
      send_item(16'h1234, 1'b0, 1'b1, 1'b0);
      send_item(16'hFFFF, 1'b0, 1'b0, 1'b0);   // subset of set 0, dropped
      send_item(16'h0000, 1'b0, 1'b1, 1'b0);
      send_item(16'hA5A5, 1'b1, 1'b0, 1'b0);   // no element, no close: ignored
      send_item(16'h5A5A, 1'b1, 1'b1, 1'b0);   // empty set, never a subset
      send_item(16'h1234, 1'b0, 1'b0, 1'b0);
      send_item(16'h8001, 1'b0, 1'b0, 1'b1);   // list close without set_last

      // minimal mode
      write_mode(KEEP_MINIMAL);
      send_item(16'h00FF, 1'b0, 1'b0, 1'b0);
      send_item(16'h7F00, 1'b0, 1'b1, 1'b0);
      send_item(16'h7F00, 1'b0, 1'b0, 1'b0);   // superset of set 0, dropped
      send_item(16'h00FF, 1'b0, 1'b0, 1'b0);
      send_item(16'h5555, 1'b0, 1'b1, 1'b0);
      send_item(16'h00FF, 1'b0, 1'b0, 1'b0);   // repeated key
      send_item(16'h00FF, 1'b0, 1'b1, 1'b0);
      send_item(16'h0001, 1'b1, 1'b0, 1'b1);   // list close makes an empty set
      send_item(16'hC3C3, 1'b0, 1'b1, 1'b1);   // one-set list, both flags

      // set store full: 34 sets, the last closes and their keys are dropped
      write_mode(KEEP_MAXIMAL);
      send_list(34, 3, 1'b1, spare_count);

      // element store full, sent right behind so it stalls during the hold-off:
      // a small set, then one that runs past the store and keeps what fit
      base = mmsf_pkg::ELEMENT_KEY_W'($urandom);
      for (i = 0; i < 3; i++)
         send_item(base ^ mmsf_pkg::ELEMENT_KEY_W'($urandom_range(3)), 1'b0,
                   i == 2, 1'b0);
      for (i = 0; i < 257; i++)
         send_item(base ^ mmsf_pkg::ELEMENT_KEY_W'($urandom_range(3)), 1'b0,
                   i == 256, i == 256);

      // random lists; the first few go without sender gaps, and lists either
      // stream back to back or wait for a mode change
      while (random_items < RANDOM_ITEMS) begin
         sender_steady = (list_no < 4);
         if ($urandom_range(2) == 0)
            write_mode(1'($urandom_range(1)));
         send_list($urandom_range(1, 8), 5, $urandom_range(3) != 0, random_items);
         list_no++;
      end
      sender_steady = 1'b0;

      wait_drained();
      if (mismatch_count == 0 && keeps_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
